>>> hw/rtl/packet_framer_fletcher8_macros.svh
// Assertion macros shared by the framer's checker.
`ifndef PACKET_FRAMER_FLETCHER8_MACROS_SVH
`define PACKET_FRAMER_FLETCHER8_MACROS_SVH

// Check a property on the rising clock edge, masked while reset is high.
`define PF8_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on the rising clock edge, also during reset.
`define PF8_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/pf8_pkg.sv
// Types and constants of the Fletcher-8 packet framer.
package pf8_pkg;

   // Action codes of a request beat
   localparam logic ActStart = 1'b0;
   localparam logic ActData  = 1'b1;

   // Configuration register indexes
   localparam logic CsrHeaderFirst  = 1'b0;
   localparam logic CsrHeaderSecond = 1'b1;

   // Reset values of the sync bytes
   localparam logic [7:0] HeaderFirstReset  = 8'hAA;
   localparam logic [7:0] HeaderSecondReset = 8'h55;

   // Longest burst one request causes, and the result queue depth
   localparam int BurstMax   = 5;
   localparam int QueueDepth = BurstMax + 1;
   localparam int CountW     = $clog2(QueueDepth + 1);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       frame_end;
      logic       stray_error;
   } result_type;

endpackage

>>> hw/rtl/pf8_channels.sv
// Valid/ready channel interfaces of the framer: request and response.
interface pf8_req_if import pf8_pkg::*;;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] msg_length;
   logic [7:0] data_byte;

   modport source (output valid, action, msg_length, data_byte, input ready);
   modport sink   (input valid, action, msg_length, data_byte, output ready);
endinterface

interface pf8_rsp_if import pf8_pkg::*;;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;
   logic       frame_end;
   logic       stray_error;

   modport source (output valid, out_byte, last_of_run, frame_end, stray_error,
                   input ready);
   modport sink   (input valid, out_byte, last_of_run, frame_end, stray_error,
                   output ready);
endinterface

>>> hw/rtl/packet_framer_fletcher8.sv
// Top level of the Fletcher-8 packet framer.
//
// Usage: a start beat on req_bus (action 0) carries the payload length and
// yields the two sync bytes and the length byte on rsp_bus; a zero length
// also yields both checksum bytes, closing the frame at once. Each data beat
// (action 1) echoes its byte; the last one of a frame is followed by sum A
// and sum B, the latter flagged frame_end. A data beat with no frame open
// yields one zero byte flagged stray_error. A start beat inside an open
// frame drops that frame and begins a new one.
// Every response beat carries last_of_run on the final beat of its request.
// The response beats of a request are registered into the response queue
// before they reach rsp_bus. The single response port passes one response
// beat per cycle while the receiver is ready; a request is taken whenever
// at most one response beat is queued, so with a ready receiver data beats
// flow at one per cycle, and a start beat yields three or five beats.
// The six-entry response queue keeps req_bus.ready independent of
// rsp_bus.ready. When the receiver stalls, the queue holds and req_bus.ready
// drops once more than one beat waits. Synchronous reset empties the queue,
// closes any frame and restores the sync bytes to 0xAA and 0x55.
// The csr_ port writes sync bytes; write them only while the block is idle.
module packet_framer_fletcher8 import pf8_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pf8_req_if.sink    req_bus,
   pf8_rsp_if.source  rsp_bus,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic [7:0]        hdr_first_ff, hdr_second_ff;
   logic              open_ff, open_in;
   logic [7:0]        left_ff, left_in;
   logic [7:0]        sum_a_ff, sum_a_in;
   logic [7:0]        sum_b_ff, sum_b_in;
   result_type        entry_ff [QueueDepth];
   result_type        entry_in [QueueDepth];
   logic [CountW-1:0] count_ff, count_in;

   result_type        burst   [QueueDepth];
   result_type        shifted [QueueDepth];
   result_type        placed  [QueueDepth];
   logic [CountW-1:0] burst_n;
   logic [CountW-1:0] kept;
   logic              load, pop;
   logic [7:0]        acc_a, acc_b, left_dec;

   // Accept a request while at most one response beat waits
   assign req_bus.ready = (count_ff <= CountW'(1));
   assign load          = req_bus.valid && req_bus.ready;
   assign pop           = rsp_bus.valid && rsp_bus.ready;

   // Present the queue head
   assign rsp_bus.valid       = (count_ff != '0);
   assign rsp_bus.out_byte    = entry_ff[0].out_byte;
   assign rsp_bus.last_of_run = entry_ff[0].last_of_run;
   assign rsp_bus.frame_end   = entry_ff[0].frame_end;
   assign rsp_bus.stray_error = entry_ff[0].stray_error;

   // Fletcher step on the incoming data byte
   assign acc_a    = sum_a_ff + req_bus.data_byte;
   assign acc_b    = sum_b_ff + acc_a;
   assign left_dec = left_ff - 8'd1;

   // Build the burst and the next frame state for this request
   always_comb begin
      for (int i = 0; i < QueueDepth; i++) begin
         burst[i] = '0;
      end
      burst_n  = CountW'(1);
      open_in  = open_ff;
      left_in  = left_ff;
      sum_a_in = sum_a_ff;
      sum_b_in = sum_b_ff;
      if (req_bus.action == ActStart) begin
         sum_a_in = req_bus.msg_length;
         sum_b_in = req_bus.msg_length;
         left_in  = req_bus.msg_length;
         open_in  = (req_bus.msg_length != 8'd0);
         burst[0].out_byte = hdr_first_ff;
         burst[1].out_byte = hdr_second_ff;
         burst[2].out_byte = req_bus.msg_length;
         if (req_bus.msg_length == 8'd0) begin
            burst[3].out_byte    = req_bus.msg_length;
            burst[4].out_byte    = req_bus.msg_length;
            burst[4].last_of_run = 1'b1;
            burst[4].frame_end   = 1'b1;
            burst_n              = CountW'(5);
         end else begin
            burst[2].last_of_run = 1'b1;
            burst_n              = CountW'(3);
         end
      end else if (!open_ff || left_ff == 8'd0) begin
         // Flag a stray payload byte; state holds
         burst[0].last_of_run = 1'b1;
         burst[0].stray_error = 1'b1;
      end else begin
         sum_a_in          = acc_a;
         sum_b_in          = acc_b;
         left_in           = left_dec;
         burst[0].out_byte = req_bus.data_byte;
         if (left_dec != 8'd0) begin
            burst[0].last_of_run = 1'b1;
         end else begin
            open_in              = 1'b0;
            burst[1].out_byte    = acc_a;
            burst[2].out_byte    = acc_b;
            burst[2].last_of_run = 1'b1;
            burst[2].frame_end   = 1'b1;
            burst_n              = CountW'(3);
         end
      end
   end

   // Advance the queue on a pop, then append the new burst behind what stays
   always_comb begin
      kept = count_ff - CountW'(pop);
      for (int i = 0; i < QueueDepth - 1; i++) begin
         shifted[i] = pop ? entry_ff[i + 1] : entry_ff[i];
      end
      shifted[QueueDepth - 1] = entry_ff[QueueDepth - 1];
      placed[0] = (kept == CountW'(1)) ? shifted[0] : burst[0];
      for (int i = 1; i < QueueDepth; i++) begin
         placed[i] = (kept == CountW'(1)) ? burst[i - 1] : burst[i];
      end
      for (int i = 0; i < QueueDepth; i++) begin
         entry_in[i] = load ? placed[i] : shifted[i];
      end
      count_in = load ? kept + burst_n : kept;
   end

   // Queue payload
   always_ff @(posedge clock) begin
      for (int i = 0; i < QueueDepth; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

   // Queue count and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         open_ff  <= 1'b0;
         left_ff  <= '0;
         sum_a_ff <= '0;
         sum_b_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (load) begin
            open_ff  <= open_in;
            left_ff  <= left_in;
            sum_a_ff <= sum_a_in;
            sum_b_ff <= sum_b_in;
         end
      end
   end

   // Sync byte registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_first_ff  <= HeaderFirstReset;
         hdr_second_ff <= HeaderSecondReset;
      end else if (csr_we) begin
         case (csr_index)
            CsrHeaderFirst:  hdr_first_ff  <= csr_wdata;
            CsrHeaderSecond: hdr_second_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

>>> hw/rtl/pf8_checker.sv
// Port-level checks of the framer, bound to its top level.
`include "packet_framer_fletcher8_macros.svh"

module pf8_checker import pf8_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       last_of_run,
   input logic       frame_end,
   input logic       stray_error
);

   // Hold a stalled response beat
   `PF8_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(last_of_run), "stalled response beat changed")

   // A closing checksum ends its burst
   `PF8_ASSERT(a_end_last, clock, reset, rsp_valid && frame_end |-> last_of_run && !stray_error, "frame_end without last_of_run")

   // An error beat is a lone zero byte
   `PF8_ASSERT(a_err_beat, clock, reset, rsp_valid && stray_error |-> out_byte == 8'd0 && last_of_run && !frame_end, "malformed error beat")

   // Reset drains the queue
   `PF8_ASSERT_ALWAYS(a_rst_empty, clock, reset |=> !rsp_valid, "response valid after reset")

endmodule

bind packet_framer_fletcher8 pf8_checker u_pf8_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .out_byte    (rsp_bus.out_byte),
   .last_of_run (rsp_bus.last_of_run),
   .frame_end   (rsp_bus.frame_end),
   .stray_error (rsp_bus.stray_error)
);
